### rtl/utf8_decoder_core_macros.svh
// assertion macros for the utf8 decoder core
// no dependencies; taken in by the rtl files that check their own logic
`ifndef UTF8_DECODER_CORE_MACROS_SVH
`define UTF8_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is low
`define UDEC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define UDEC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UDEC_ASSERT(label, clk, rst_n, prop, msg)
`define UDEC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/udec_pkg.sv
// constants and types for the utf8 decoder core
// no dependencies
`default_nettype none
package udec_pkg;

    localparam int unsigned CP_W = 21;

    // byte classes
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CODE_CONT  = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;

    // payload masks of lead and continuation bytes
    localparam logic [7:0] PAY_LEAD2 = 8'h1F;
    localparam logic [7:0] PAY_LEAD3 = 8'h0F;
    localparam logic [7:0] PAY_LEAD4 = 8'h07;
    localparam logic [7:0] PAY_CONT  = 8'h3F;

    localparam logic [CP_W-1:0] CP_BAD = 21'h00FFFD;

    // results caused by one byte: some replacement marks, then an optional tail
    typedef struct packed {
        logic [1:0]      nbad;
        logic            tail;
        logic [CP_W-1:0] cp;
        logic            eot;
    } t_bundle;

endpackage
`default_nettype wire

### rtl/utf8_decoder_core.sv
// utf8 decoder core: byte in, code points out
// depends on udec_pkg and utf8_decoder_core_macros.svh
`default_nettype none
`include "utf8_decoder_core_macros.svh"

// Streaming UTF-8 decoder. One byte is taken per beat on the input channel
// (i_valid / o_stall) and decoded code points leave one per beat on the
// output channel (o_valid / i_stall). A byte is decoded in the cycle it is
// accepted into a result bundle register; the bundle then feeds a single
// output register. Throughput is one byte per cycle as long as each byte
// gives at most one result and i_stall is low; a byte that gives several
// results (a broken sequence or a text end that flushes held bytes, up to
// four results) holds the input until its last result has moved on, since
// the output port moves one result per cycle. A zero byte ends the text
// with code_point 0 and end_of_text set; last_of_run marks the final result
// of each byte. Overlong forms and surrogates pass through decoded.
module utf8_decoder_core
    import udec_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_text_byte,
    output logic                 o_stall,
    output logic                 o_valid,
    output logic [CP_W-1:0]      o_code_point,
    output logic                 o_end_of_text,
    output logic                 o_last_of_run,
    input  wire logic            i_stall
);

    // decoder state
    logic [1:0]      r_exp, n_exp;
    logic [1:0]      r_held, n_held;
    logic [CP_W-1:0] r_acc, n_acc;

    // bundle register
    logic            r_b_valid, n_b_valid;
    t_bundle         r_b, n_b;

    // output register
    logic            r_o_valid, n_o_valid;
    logic [CP_W-1:0] r_o_cp, n_o_cp;
    logic            r_o_eot, n_o_eot;
    logic            r_o_last, n_o_last;

    logic            in_take;
    logic            o_free;
    logic            b_move;
    logic            b_final;
    t_bundle         dec;
    logic [1:0]      flush_cnt;
    logic            is_cont;
    logic [1:0]      held_inc;
    logic [CP_W-1:0] acc_shift;

    // handshake
    assign o_free  = !r_o_valid || !i_stall;
    assign b_move  = r_b_valid && o_free;
    assign b_final = (r_b.nbad == 2'd0) || ((r_b.nbad == 2'd1) && !r_b.tail);
    assign o_stall = r_b_valid && !(b_move && b_final);
    assign in_take = i_valid && !o_stall;

    // byte decode and next state
    assign is_cont   = (i_text_byte & MASK_CONT) == CODE_CONT;
    assign held_inc  = r_held + 2'd1;
    assign acc_shift = {r_acc[CP_W-7:0], i_text_byte[5:0]};
    assign flush_cnt = (r_exp == 2'd0) ? 2'd0 :
                       (r_held >= 2'd2) ? 2'd3 : held_inc;

    always_comb begin
        n_exp    = r_exp;
        n_held   = r_held;
        n_acc    = r_acc;
        dec.nbad = 2'd0;
        dec.tail = 1'b0;
        dec.cp   = CP_BAD;
        dec.eot  = 1'b0;
        if (i_text_byte == 8'h00) begin
            // end of text: flush held bytes, then end marker
            dec.nbad = flush_cnt;
            dec.tail = 1'b1;
            dec.cp   = '0;
            dec.eot  = 1'b1;
            n_exp    = 2'd0;
            n_held   = 2'd0;
            n_acc    = '0;
        end else if ((r_exp != 2'd0) && is_cont) begin
            // collect continuation, emit when the sequence completes
            if ((held_inc >= r_exp) || (held_inc == 2'd0)) begin
                dec.tail = 1'b1;
                dec.cp   = acc_shift;
                n_exp    = 2'd0;
                n_held   = 2'd0;
                n_acc    = '0;
            end else begin
                n_held = held_inc;
                n_acc  = acc_shift;
            end
        end else begin
            // broken sequence flush, then the byte as a new lead
            dec.nbad = flush_cnt;
            n_exp    = 2'd0;
            n_held   = 2'd0;
            n_acc    = '0;
            if (i_text_byte[7] == 1'b0) begin
                dec.tail = 1'b1;
                dec.cp   = {13'd0, i_text_byte};
            end else if ((i_text_byte & MASK_LEAD2) == CODE_LEAD2) begin
                n_exp = 2'd1;
                n_acc = {13'd0, i_text_byte & PAY_LEAD2};
            end else if ((i_text_byte & MASK_LEAD3) == CODE_LEAD3) begin
                n_exp = 2'd2;
                n_acc = {13'd0, i_text_byte & PAY_LEAD3};
            end else if ((i_text_byte & MASK_LEAD4) == CODE_LEAD4) begin
                n_exp = 2'd3;
                n_acc = {13'd0, i_text_byte & PAY_LEAD4};
            end else begin
                dec.tail = 1'b1;
            end
        end
    end

    // bundle register: load on input beat, count down as results leave
    always_comb begin
        n_b_valid = r_b_valid;
        n_b       = r_b;
        if (b_move) begin
            if (b_final) begin
                n_b_valid = 1'b0;
            end else begin
                n_b.nbad = r_b.nbad - 2'd1;
            end
        end
        if (in_take) begin
            n_b_valid = (dec.nbad != 2'd0) || dec.tail;
            n_b       = dec;
        end
    end

    // output register: head of the bundle
    always_comb begin
        n_o_valid = r_o_valid && i_stall;
        n_o_cp    = r_o_cp;
        n_o_eot   = r_o_eot;
        n_o_last  = r_o_last;
        if (b_move) begin
            n_o_valid = 1'b1;
            n_o_last  = b_final;
            if (r_b.nbad != 2'd0) begin
                n_o_cp  = CP_BAD;
                n_o_eot = 1'b0;
            end else begin
                n_o_cp  = r_b.cp;
                n_o_eot = r_b.eot;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp     <= 2'd0;
            r_held    <= 2'd0;
            r_acc     <= '0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_exp  <= n_exp;
                r_held <= n_held;
                r_acc  <= n_acc;
            end
            r_b_valid <= n_b_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_b      <= n_b;
        r_o_cp   <= n_o_cp;
        r_o_eot  <= n_o_eot;
        r_o_last <= n_o_last;
    end

    assign o_valid       = r_o_valid;
    assign o_code_point  = r_o_cp;
    assign o_end_of_text = r_o_eot;
    assign o_last_of_run = r_o_last;

    // checks
    `UDEC_ASSERT(a_eot_shape, i_clk, i_rst_n, (o_valid && o_end_of_text) |-> ((o_code_point == '0) && o_last_of_run), "end marker must carry code point zero and close its run")
    `UDEC_ASSERT(a_bundle_nonempty, i_clk, i_rst_n, r_b_valid |-> ((r_b.nbad != 2'd0) || r_b.tail), "valid bundle holds no result")
    `UDEC_ASSERT(a_held_below_exp, i_clk, i_rst_n, (r_exp != 2'd0) |-> (r_held < r_exp), "held count reached expected total")
    `UDEC_ASSERT(a_idle_no_held, i_clk, i_rst_n, (r_exp == 2'd0) |-> ((r_held == 2'd0) && (r_acc == '0)), "idle decoder holds bytes")
    `UDEC_ASSERT_ALWAYS(a_stall_needs_bundle, i_clk, o_stall |-> r_b_valid, "input stalled with empty bundle")

endmodule
`default_nettype wire

### tb/tb_utf8_decoder_core.sv
// self-checking testbench for utf8_decoder_core: byte beats in, code point beats out
// depends on udec_pkg and the rtl of utf8_decoder_core; a local decoder predicts each beat
`default_nettype none

module tb_utf8_decoder_core;
    import udec_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int IDLE_PCT    = 35;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eot;
        logic            last;
    } t_cp_beat;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic [7:0]      i_text_byte = 8'h00;
    logic            i_stall = 1'b0;
    logic            o_stall;
    logic            o_valid;
    logic [CP_W-1:0] o_code_point;
    logic            o_end_of_text;
    logic            o_last_of_run;

    // decoder state of the predictor
    logic [1:0]      lead_need = 2'd0;
    logic [1:0]      cont_seen = 2'd0;
    logic [CP_W-1:0] cp_acc = '0;
    t_cp_beat        run_beats[$];
    t_cp_beat        cp_expected[$];

    int  error_count = 0;
    int  bytes_sent = 0;
    int  bytes_decoded = 0;
    int  cps_checked = 0;
    int  bad_seen = 0;
    int  eot_seen = 0;
    int  cycle_count = 0;
    int  hold_goal = 0;
    int  hold_done = 0;
    bit  calm = 1'b0;

    utf8_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_text_byte   (i_text_byte),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_code_point  (o_code_point),
        .o_end_of_text (o_end_of_text),
        .o_last_of_run (o_last_of_run),
        .i_stall       (i_stall)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void add_cp(input logic [CP_W-1:0] cp, input logic eot);
        t_cp_beat beat;
        beat.cp   = cp;
        beat.eot  = eot;
        beat.last = 1'b0;
        run_beats.push_back(beat);
    endfunction

    // replacement for the open lead plus one per held continuation
    function automatic void flush_open_seq();
        if (lead_need != 2'd0) begin
            add_cp(CP_BAD, 1'b0);
            for (int i = 0; i < int'(cont_seen) && i < 2; i++)
                add_cp(CP_BAD, 1'b0);
        end
        lead_need = 2'd0;
        cont_seen = 2'd0;
        cp_acc    = '0;
    endfunction

    function automatic void start_lead(input logic [7:0] b);
        if (b < CODE_CONT) begin
            add_cp(CP_W'(b), 1'b0);
        end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            lead_need = 2'd1;
            cont_seen = 2'd0;
            cp_acc    = CP_W'(b & PAY_LEAD2);
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            lead_need = 2'd2;
            cont_seen = 2'd0;
            cp_acc    = CP_W'(b & PAY_LEAD3);
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            lead_need = 2'd3;
            cont_seen = 2'd0;
            cp_acc    = CP_W'(b & PAY_LEAD4);
        end else begin
            add_cp(CP_BAD, 1'b0);
        end
    endfunction

    // works out the code point beats one accepted byte causes
    function automatic void decode_byte(input logic [7:0] b);
        t_cp_beat beat;
        run_beats.delete();
        if (b == 8'h00) begin
            flush_open_seq();
            add_cp('0, 1'b1);
        end else if (lead_need != 2'd0) begin
            if ((b & MASK_CONT) == CODE_CONT) begin
                cp_acc    = (cp_acc << 6) | CP_W'(b & PAY_CONT);
                cont_seen = cont_seen + 2'd1;
                if (cont_seen >= lead_need || cont_seen == 2'd0) begin
                    add_cp(cp_acc, 1'b0);
                    lead_need = 2'd0;
                    cont_seen = 2'd0;
                    cp_acc    = '0;
                end
            end else begin
                flush_open_seq();
                start_lead(b);
            end
        end else begin
            start_lead(b);
        end
        for (int i = 0; i < run_beats.size(); i++) begin
            beat      = run_beats[i];
            beat.last = (i == run_beats.size() - 1);
            cp_expected.push_back(beat);
        end
    endfunction

    // input monitor: predict on every accepted byte beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            decode_byte(i_text_byte);
            bytes_decoded <= bytes_decoded + 1;
        end
    end

    // output checker: compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin
        t_cp_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cp_expected.size() == 0) begin
                $error("unexpected result: code_point %h end_of_text %b last_of_run %b",
                       o_code_point, o_end_of_text, o_last_of_run);
                error_count++;
            end else begin
                want = cp_expected.pop_front();
                cps_checked++;
                if (want.cp == CP_BAD) bad_seen++;
                if (want.eot) eot_seen++;
                if (o_code_point !== want.cp) begin
                    $error("code_point mismatch: expected %h, got %h", want.cp, o_code_point);
                    error_count++;
                end
                if (o_end_of_text !== want.eot) begin
                    $error("end_of_text mismatch: expected %b, got %b",
                           want.eot, o_end_of_text);
                    error_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run mismatch: expected %b, got %b",
                           want.last, o_last_of_run);
                    error_count++;
                end
            end
        end
    end

    // receiver stall: long hold on request, none when calm, random otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_done < hold_goal) begin
            i_stall   <= 1'b1;
            hold_done <= hold_done + 1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_utf8_decoder_core failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // offer one byte beat, with random idle cycles ahead of it unless calm
    task automatic send_byte(input logic [7:0] b);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_seq(input logic [7:0] seq[]);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // sender stops until every expected code point has come out
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (cp_expected.size() != 0);
    endtask

    // lead of a seq_len byte sequence followed by n_cont continuations
    task automatic send_multibyte(input int seq_len, input int n_cont);
        logic [7:0] lead;
        case (seq_len)
            2:       lead = CODE_LEAD2 | 8'($urandom_range(0, 31));
            3:       lead = CODE_LEAD3 | 8'($urandom_range(0, 15));
            default: lead = CODE_LEAD4 | 8'($urandom_range(0, 7));
        endcase
        send_byte(lead);
        repeat (n_cont) send_byte(CODE_CONT | 8'($urandom_range(0, 63)));
    endtask

    // mostly well-formed text, with broken sequences, strays, text ends and noise mixed in
    task automatic send_random_text(input int n_bytes);
        int start;
        int pick;
        int seq_len;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_byte(8'($urandom_range(1, 127)));
            end else if (pick < 77) begin
                seq_len = (pick < 55) ? 2 : (pick < 67) ? 3 : 4;
                send_multibyte(seq_len, seq_len - 1);
            end else if (pick < 85) begin
                seq_len = $urandom_range(2, 4);
                send_multibyte(seq_len, $urandom_range(0, seq_len - 2));
            end else if (pick < 90) begin
                if ($urandom_range(1))
                    send_byte(CODE_CONT | 8'($urandom_range(0, 63)));
                else
                    send_byte(MASK_LEAD4 | 8'($urandom_range(0, 7)));
            end else if (pick < 95) begin
                send_byte(8'h00);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_single_byte_chars();
        send_seq('{8'h01, 8'h7F, 8'h41});
    endtask

    // shortest two byte, largest three byte, largest four byte payload
    task automatic test_full_sequences();
        send_seq('{8'hC2, 8'h80});
        send_seq('{8'hEF, 8'hBF, 8'hBF});
        send_seq('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
    endtask

    task automatic test_stray_and_invalid();
        send_seq('{8'h80, 8'hBF, 8'hF8, 8'hFF});
    endtask

    // four byte lead cut by ascii gives four beats; two byte lead cut by an invalid byte
    task automatic test_broken_sequences();
        send_seq('{8'hF0, 8'h90, 8'h80, 8'h41});
        send_seq('{8'hC3, 8'hF8});
    endtask

    // end of text with held bytes to flush, then a bare end
    task automatic test_end_of_text();
        send_seq('{8'hE2, 8'h82, 8'h00});
        send_byte(8'h00);
        pause_until_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_goal = hold_goal + HOLD_CYCLES;
        send_random_text(40);
        pause_until_drained();
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        send_random_text(60);
        calm = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte_chars();
        test_full_sequences();
        test_stray_and_invalid();
        test_broken_sequences();
        test_end_of_text();
        send_random_text(200);
        test_backpressure();
        test_no_idle();

        // let the pipeline settle and catch any extra beats
        pause_until_drained();
        repeat (10) @(posedge i_clk);

        $display("decoded %0d text bytes into %0d code points (%0d replacements, %0d text ends)",
                 bytes_decoded, cps_checked, bad_seen, eot_seen);
        $display("covered lead/continuation forms, broken and stray bytes, backpressure");
        if (error_count == 0) begin
            $display("tb_utf8_decoder_core passed");
        end else begin
            $display("tb_utf8_decoder_core failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
